// File: rtl/core/keyed_deadline_queue_top_assert.svh
// assertion macros used by the queue top rtl
`ifndef KEYED_DEADLINE_QUEUE_TOP_ASSERT_SVH
`define KEYED_DEADLINE_QUEUE_TOP_ASSERT_SVH

// same-cycle implication under reset
`define KDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define KDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/kdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_pkg
// Shared constants and types of the keyed deadline queue.
// ----------------------------------------------------------------------------
package kdq_pkg;

    localparam int SLOT_VERSIONS = 32;
    localparam int CAPACITY      = 2 * SLOT_VERSIONS;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int SLOT_W        = 64;
    localparam int ID_W          = 256;
    localparam int DL_W          = 64;
    localparam int Q_W           = 32;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_QUERY   = 3'd1;
    localparam logic [2:0] ACT_REMOVE  = 3'd2;
    localparam logic [2:0] ACT_POP     = 3'd3;
    localparam logic [2:0] ACT_PUBLISH = 3'd4;

    localparam logic signed [DL_W-1:0] DL_MAX = {1'b0, {(DL_W-1){1'b1}}};

    // request to the deadline truncation unit
    typedef struct packed {
        logic                   start;
        logic signed [DL_W-1:0] value;
        logic [Q_W-1:0]         quantum;
    } trunc_req_t;

    // response of the deadline truncation unit
    typedef struct packed {
        logic                   done;
        logic signed [DL_W-1:0] value;
    } trunc_rsp_t;

endpackage

// File: rtl/core/keyed_deadline_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_deadline_queue_top
// Bounded table of pending checks keyed by slot and block id, with deadlines.
// ----------------------------------------------------------------------------
// One item is taken at a time: the table lives in single-read-port rams,
// and every operation sweeps all 64 entries one per cycle through the
// registered read port, then writes back in a commit state, which waits
// for the truncation and for the output register to be free. The deadline
// truncation runs in parallel on a bit-serial unit. A finished result sits
// in an output register, so the next item can be taken while it waits. The
// quantum register may be written whenever no item is in flight.
module keyed_deadline_queue_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [kdq_pkg::Q_W-1:0]     cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  action,
    input  logic [63:0]                 slot,
    input  logic [63:0]                 block_id_w0,
    input  logic [63:0]                 block_id_w1,
    input  logic [63:0]                 block_id_w2,
    input  logic [63:0]                 block_id_w3,
    input  logic signed [63:0]          time_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic                        found,
    output logic [63:0]                 out_slot,
    output logic [63:0]                 out_id_w0,
    output logic [63:0]                 out_id_w1,
    output logic [63:0]                 out_id_w2,
    output logic [63:0]                 out_id_w3,
    output logic [kdq_pkg::CNT_W-1:0]   queued_count,
    output logic signed [63:0]          earliest_deadline
);
    import kdq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [Q_W-1:0]         quantum_reg;
    logic [CAPACITY-1:0]    valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       scan_cnt_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;

    logic [2:0]             act_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [ID_W-1:0]        id_reg;
    logic signed [DL_W-1:0] tv_reg;

    logic                   match_hit_reg;
    logic [IDX_W-1:0]       match_idx_reg;
    logic signed [DL_W-1:0] match_dl_reg;
    logic                   free_hit_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    logic                   best_hit_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic signed [DL_W-1:0] best_dl_reg;
    logic [SLOT_W-1:0]      best_slot_reg;
    logic [ID_W-1:0]        best_id_reg;
    logic signed [DL_W-1:0] second_dl_reg;
    logic signed [DL_W-1:0] emin_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   status_reg;
    logic                   found_reg;
    logic [SLOT_W-1:0]      oslot_reg;
    logic [ID_W-1:0]        oid_reg;
    logic [CNT_W-1:0]       ocount_reg;
    logic signed [DL_W-1:0] oearly_reg;

    logic                   accept;
    logic                   issue;
    logic                   commit;
    logic                   scan_last;
    trunc_req_t             trunc_req;
    trunc_rsp_t             trunc_rsp;

    logic [SLOT_W-1:0]      e_slot;
    logic [ID_W-1:0]        e_id;
    logic [DL_W-1:0]        e_dl_raw;
    logic signed [DL_W-1:0] e_dl;
    logic                   e_valid;
    logic                   e_match;
    logic                   e_pub;
    logic                   e_keep;
    logic                   e_better;

    logic                   we_new;
    logic                   we_dl;
    logic [IDX_W-1:0]       waddr;
    logic                   c_status;
    logic                   c_found;
    logic signed [DL_W-1:0] c_early;
    logic signed [DL_W-1:0] ins_min;
    logic                   pop_hit;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign issue    = (state_reg == S_SCAN) && (scan_cnt_reg < CNT_W'(CAPACITY));
    assign scan_last = rd_vld_reg && (rd_idx_reg == IDX_W'(CAPACITY - 1));
    assign commit   = (state_reg == S_COMMIT) && trunc_rsp.done &&
                      (!out_valid_reg || out_ready);

    // deadline truncation
    assign trunc_req.start   = accept;
    assign trunc_req.value   = time_value;
    assign trunc_req.quantum = quantum_reg;

    kdq_trunc u_trunc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trunc_req),
        .rsp   (trunc_rsp)
    );

    // table memories
    kdq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
        .clk   (clk),
        .we    (we_new),
        .waddr (waddr),
        .wdata (slot_reg),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (e_slot)
    );

    kdq_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_ram (
        .clk   (clk),
        .we    (we_new),
        .waddr (waddr),
        .wdata (id_reg),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (e_id)
    );

    kdq_ram #(.WIDTH(DL_W), .DEPTH(CAPACITY)) u_dl_ram (
        .clk   (clk),
        .we    (we_dl),
        .waddr (waddr),
        .wdata (trunc_rsp.value),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (e_dl_raw)
    );

    // per-entry evaluation of the read beat
    always_comb
    begin
        e_dl     = $signed(e_dl_raw);
        e_valid  = valid_reg[rd_idx_reg];
        e_match  = e_valid && (e_slot == slot_reg) && (e_id == id_reg);
        e_pub    = e_valid && (act_reg == ACT_PUBLISH) && (e_slot <= slot_reg);
        e_keep   = e_valid && !((act_reg == ACT_REMOVE) && e_match) && !e_pub;
        e_better = !best_hit_reg || (e_dl < best_dl_reg) ||
                   ((e_dl == best_dl_reg) && (e_slot < best_slot_reg));
    end

    // write-back decision
    always_comb
    begin
        ins_min  = (trunc_rsp.value < emin_reg) ? trunc_rsp.value : emin_reg;
        pop_hit  = best_hit_reg && (best_dl_reg <= tv_reg);
        we_new   = 1'b0;
        we_dl    = 1'b0;
        waddr    = free_idx_reg;
        c_status = 1'b0;
        c_found  = 1'b0;
        c_early  = emin_reg;
        unique case (act_reg)
            ACT_INSERT:
            begin
                if (match_hit_reg)
                begin
                    waddr   = match_idx_reg;
                    we_dl   = commit && (trunc_rsp.value < match_dl_reg);
                    c_early = ins_min;
                end
                else if (free_hit_reg && (count_reg != CNT_W'(CAPACITY)))
                begin
                    we_new  = commit;
                    we_dl   = commit;
                    c_early = ins_min;
                end
                else
                begin
                    c_status = 1'b1;
                end
            end
            ACT_QUERY:
            begin
                c_found = match_hit_reg;
            end
            ACT_POP:
            begin
                c_found = pop_hit;
                if (pop_hit)
                begin
                    c_early = second_dl_reg;
                end
            end
            default:
            begin
                c_early = emin_reg;
            end
        endcase
    end

    // valid bits, count and state
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_vld_reg && e_pub)
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                    count_next             = count_reg - 1'b1;
                end
                if (scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                    if (we_new)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                        count_next               = count_reg + 1'b1;
                    end
                    else if ((act_reg == ACT_REMOVE) && match_hit_reg)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                        count_next                = count_reg - 1'b1;
                    end
                    else if ((act_reg == ACT_POP) && pop_hit)
                    begin
                        valid_next[best_idx_reg] = 1'b0;
                        count_next               = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quantum_reg   <= Q_W'(1);
            valid_reg     <= '0;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rd_vld_reg    <= issue;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                quantum_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    // item capture and scan accumulators
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (accept)
        begin
            act_reg       <= action;
            slot_reg      <= slot;
            id_reg        <= {block_id_w3, block_id_w2, block_id_w1, block_id_w0};
            tv_reg        <= time_value;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            best_hit_reg  <= 1'b0;
            best_dl_reg   <= DL_MAX;
            best_slot_reg <= '0;
            second_dl_reg <= DL_MAX;
            emin_reg      <= DL_MAX;
        end
        else if (rd_vld_reg && (state_reg == S_SCAN))
        begin
            if (e_match && !match_hit_reg)
            begin
                match_hit_reg <= 1'b1;
                match_idx_reg <= rd_idx_reg;
                match_dl_reg  <= e_dl;
            end
            if (!e_valid && !free_hit_reg)
            begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            if (e_keep && (e_dl < emin_reg))
            begin
                emin_reg <= e_dl;
            end
            if (e_valid)
            begin
                if (e_better)
                begin
                    best_hit_reg  <= 1'b1;
                    best_idx_reg  <= rd_idx_reg;
                    best_dl_reg   <= e_dl;
                    best_slot_reg <= e_slot;
                    best_id_reg   <= e_id;
                    if (best_hit_reg && (best_dl_reg < second_dl_reg))
                    begin
                        second_dl_reg <= best_dl_reg;
                    end
                end
                else if (e_dl < second_dl_reg)
                begin
                    second_dl_reg <= e_dl;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= c_status;
            found_reg  <= c_found;
            oslot_reg  <= ((act_reg == ACT_POP) && pop_hit) ? best_slot_reg : '0;
            oid_reg    <= ((act_reg == ACT_POP) && pop_hit) ? best_id_reg : '0;
            ocount_reg <= count_next;
            oearly_reg <= c_early;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign found             = found_reg;
    assign out_slot          = oslot_reg;
    assign out_id_w0         = oid_reg[63:0];
    assign out_id_w1         = oid_reg[127:64];
    assign out_id_w2         = oid_reg[191:128];
    assign out_id_w3         = oid_reg[255:192];
    assign queued_count      = ocount_reg;
    assign earliest_deadline = oearly_reg;

`include "keyed_deadline_queue_top_assert.svh"

    `KDQ_ASSERT_NOW(a_count_matches_valid, clk, rst_n, 1'b1, $countones(valid_reg) == count_reg, "held count disagrees with valid bits")
    `KDQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY), "held count above capacity")
    `KDQ_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept, (state_reg == S_SCAN) && (scan_cnt_reg == '0), "accepted beat did not start a sweep")
    `KDQ_ASSERT_NOW(a_commit_needs_trunc, clk, rst_n, commit, trunc_rsp.done && (state_reg == S_COMMIT), "write-back before truncation finished")

endmodule

// File: rtl/core/kdq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module kdq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/kdq_trunc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_trunc
// Truncates a signed deadline toward zero to a multiple of the quantum,
// using a bit-serial restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module kdq_trunc (
    input  logic                clk,
    input  logic                rst_n,
    input  kdq_pkg::trunc_req_t req,
    output kdq_pkg::trunc_rsp_t rsp
);
    import kdq_pkg::*;

    localparam int STEP_W = $clog2(DL_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic [DL_W-1:0]   mag_reg;
    logic [DL_W-1:0]   shift_reg;
    logic [Q_W-1:0]    q_reg;
    logic [Q_W-1:0]    rem_reg;
    logic [DL_W-1:0]   val_reg;

    logic [Q_W:0]      rem_try;
    logic [Q_W:0]      rem_sub;
    logic [Q_W-1:0]    rem_next;
    logic [DL_W-1:0]   mag_in;
    logic [DL_W-1:0]   diff;

    // one restoring step
    always_comb
    begin
        rem_try  = {rem_reg, shift_reg[DL_W-1]};
        rem_sub  = rem_try - {1'b0, q_reg};
        rem_next = (rem_try >= {1'b0, q_reg}) ? rem_sub[Q_W-1:0] : rem_try[Q_W-1:0];
        mag_in   = req.value[DL_W-1] ? (~req.value + 1'b1) : req.value;
        diff     = mag_reg - {{(DL_W-Q_W){1'b0}}, rem_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(DL_W))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg   <= req.value[DL_W-1];
            mag_reg   <= mag_in;
            shift_reg <= mag_in;
            q_reg     <= (req.quantum == '0) ? Q_W'(1) : req.quantum;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(DL_W))
            begin
                val_reg <= neg_reg ? (~diff + 1'b1) : diff;
            end
            else
            begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[DL_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = $signed(val_reg);

endmodule

// File: verif/kdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdq_checker
// Watches the request and result channels of the keyed deadline queue, keeps
// its own copy of the table, predicts each result and compares field by field.
// ----------------------------------------------------------------------------
module kdq_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [kdq_pkg::Q_W-1:0]   cfg_wr_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [2:0]                action,
    input  logic [63:0]               slot,
    input  logic [63:0]               block_id_w0,
    input  logic [63:0]               block_id_w1,
    input  logic [63:0]               block_id_w2,
    input  logic [63:0]               block_id_w3,
    input  logic signed [63:0]        time_value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      status,
    input  logic                      found,
    input  logic [63:0]               out_slot,
    input  logic [63:0]               out_id_w0,
    input  logic [63:0]               out_id_w1,
    input  logic [63:0]               out_id_w2,
    input  logic [63:0]               out_id_w3,
    input  logic [kdq_pkg::CNT_W-1:0] queued_count,
    input  logic signed [63:0]        earliest_deadline,
    output int                        fail_count,
    output int                        pending_results,
    output int                        result_count,
    output int                        pop_hits,
    output int                        full_drops
);
    import kdq_pkg::*;

    typedef struct packed {
        logic                   status;
        logic                   found;
        logic [63:0]            oslot;
        logic [255:0]           oid;
        logic [CNT_W-1:0]       count;
        logic signed [63:0]     earliest;
    } kdq_result_t;

    // shadow table
    logic [Q_W-1:0]          sh_quantum;
    logic                    sh_valid [CAPACITY];
    logic [63:0]             sh_slot [CAPACITY];
    logic [255:0]            sh_id [CAPACITY];
    logic signed [63:0]      sh_deadline [CAPACITY];
    int                      sh_count;

    kdq_result_t expected_results [$];

    function automatic logic signed [63:0] round_deadline(logic signed [63:0] t);
        logic signed [63:0] q;
        q = (sh_quantum == 0) ? 64'sd1 : $signed({32'd0, sh_quantum});
        return t - (t % q);
    endfunction

    function automatic int lookup_key(logic [63:0] s, logic [255:0] id);
        for (int i = 0; i < CAPACITY; i++)
            if (sh_valid[i] && sh_slot[i] == s && sh_id[i] == id)
                return i;
        return -1;
    endfunction

    task automatic apply_request(logic [2:0] act, logic [63:0] s, logic [255:0] id,
                                 logic signed [63:0] tv);
        kdq_result_t r;
        int k;
        int i;
        logic signed [63:0] d;
        r = '0;
        r.earliest = DL_MAX;
        if (act == ACT_INSERT)
        begin
            d = round_deadline(tv);
            k = lookup_key(s, id);
            if (k >= 0)
            begin
                if (d < sh_deadline[k])
                    sh_deadline[k] = d;
            end
            else
            begin
                i = 0;
                while (i < CAPACITY && sh_valid[i])
                    i++;
                if (i >= CAPACITY)
                begin
                    r.status = 1'b1;
                    full_drops++;
                end
                else
                begin
                    sh_valid[i] = 1'b1;
                    sh_slot[i] = s;
                    sh_id[i] = id;
                    sh_deadline[i] = d;
                    sh_count++;
                end
            end
        end
        else if (act == ACT_QUERY)
        begin
            r.found = lookup_key(s, id) >= 0;
        end
        else if (act == ACT_REMOVE)
        begin
            k = lookup_key(s, id);
            if (k >= 0)
            begin
                sh_valid[k] = 1'b0;
                sh_count--;
            end
        end
        else if (act == ACT_POP)
        begin
            k = -1;
            for (i = 0; i < CAPACITY; i++)
            begin
                if (sh_valid[i] && (k < 0 || sh_deadline[i] < sh_deadline[k] ||
                    (sh_deadline[i] == sh_deadline[k] && sh_slot[i] < sh_slot[k])))
                    k = i;
            end
            if (k >= 0 && sh_deadline[k] <= tv)
            begin
                r.found = 1'b1;
                r.oslot = sh_slot[k];
                r.oid = sh_id[k];
                sh_valid[k] = 1'b0;
                sh_count--;
                pop_hits++;
            end
        end
        else if (act == ACT_PUBLISH)
        begin
            for (i = 0; i < CAPACITY; i++)
                if (sh_valid[i] && sh_slot[i] <= s)
                begin
                    sh_valid[i] = 1'b0;
                    sh_count--;
                end
        end
        for (i = 0; i < CAPACITY; i++)
            if (sh_valid[i] && sh_deadline[i] < r.earliest)
                r.earliest = sh_deadline[i];
        r.count = sh_count[CNT_W-1:0];
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kdq_result_t e;
        kdq_result_t a;
        if (!rst_n)
        begin
            sh_quantum = 1;
            sh_count = 0;
            for (int i = 0; i < CAPACITY; i++)
                sh_valid[i] = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending_results = 0;
            result_count = 0;
            pop_hits = 0;
            full_drops = 0;
        end
        else
        begin
            if (cfg_wr_en)
                sh_quantum = cfg_wr_data;
            // compare result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                a.status = status;
                a.found = found;
                a.oslot = out_slot;
                a.oid = {out_id_w3, out_id_w2, out_id_w1, out_id_w0};
                a.count = queued_count;
                a.earliest = earliest_deadline;
                result_count++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("error: unexpected result beat %p", a);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (a !== e)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("error: result %0d mismatch\n  exp %p\n  got %p",
                                     result_count, e, a);
                    end
                end
            end
            // request beat updates the shadow table
            if (in_valid && in_ready)
                apply_request(action, slot,
                              {block_id_w3, block_id_w2, block_id_w1, block_id_w0},
                              time_value);
            pending_results = expected_results.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the keyed deadline queue: directed corner cases, then random
// key sequences over a small key pool under several quantum settings.
// ----------------------------------------------------------------------------
module tb;
    import kdq_pkg::*;

    localparam int MAX_CYCLES = 2_000_000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [Q_W-1:0]         cfg_wr_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [2:0]             action;
    logic [63:0]            slot;
    logic [63:0]            block_id_w0;
    logic [63:0]            block_id_w1;
    logic [63:0]            block_id_w2;
    logic [63:0]            block_id_w3;
    logic signed [63:0]     time_value;
    logic                   out_valid;
    logic                   out_ready;
    logic                   status;
    logic                   found;
    logic [63:0]            out_slot;
    logic [63:0]            out_id_w0;
    logic [63:0]            out_id_w1;
    logic [63:0]            out_id_w2;
    logic [63:0]            out_id_w3;
    logic [CNT_W-1:0]       queued_count;
    logic signed [63:0]     earliest_deadline;

    int fail_count;
    int pending_results;
    int result_count;
    int pop_hits;
    int full_drops;
    int cycle_count = 0;
    int sent_count;

    // key pool so that random requests hit held entries
    logic [63:0]  pool_slot [16];
    logic [255:0] pool_id [16];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    keyed_deadline_queue_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .action            (action),
        .slot              (slot),
        .block_id_w0       (block_id_w0),
        .block_id_w1       (block_id_w1),
        .block_id_w2       (block_id_w2),
        .block_id_w3       (block_id_w3),
        .time_value        (time_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .found             (found),
        .out_slot          (out_slot),
        .out_id_w0         (out_id_w0),
        .out_id_w1         (out_id_w1),
        .out_id_w2         (out_id_w2),
        .out_id_w3         (out_id_w3),
        .queued_count      (queued_count),
        .earliest_deadline (earliest_deadline)
    );

    kdq_checker u_checker (.*);

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side stalls, redrawn after every beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff out_valid);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // valid stays high after an accept only when the next beat follows at once
    task automatic send_beat(logic [2:0] act, logic [63:0] s, logic [255:0] id,
                             logic signed [63:0] tv);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        slot        <= s;
        block_id_w0 <= id[63:0];
        block_id_w1 <= id[127:64];
        block_id_w2 <= id[191:128];
        block_id_w3 <= id[255:192];
        time_value  <= tv;
        @(posedge clk iff in_ready);
        sent_count++;
    endtask

    // drop valid and wait until every result has left
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_quantum(logic [Q_W-1:0] q);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= q;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int p;
        int r;
        logic [63:0] s;
        logic [255:0] id;
        for (int i = 0; i < n; i++)
        begin
            p = $urandom_range(0, 15);
            s = pool_slot[p];
            id = pool_id[p];
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
            begin
                s = rand64();
                id = {rand64(), rand64(), rand64(), rand64()};
            end
            if (r < 40)
                send_beat(ACT_INSERT, s, id, $signed(rand64()) >>> $urandom_range(0, 60));
            else if (r < 52)
                send_beat(ACT_QUERY, s, id, $signed(rand64()));
            else if (r < 64)
                send_beat(ACT_REMOVE, s, id, $signed(rand64()));
            else if (r < 88)
                send_beat(ACT_POP, rand64(), id,
                          $signed(rand64()) >>> $urandom_range(0, 62));
            else if (r < 95)
                send_beat(ACT_PUBLISH, 64'($urandom_range(0, 40)), id, $signed(rand64()));
            else
                send_beat(3'($urandom_range(5, 7)), s, id, $signed(rand64()));
        end
    endtask

    initial
    begin
        logic [255:0] id;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        action = '0;
        slot = '0;
        block_id_w0 = '0;
        block_id_w1 = '0;
        block_id_w2 = '0;
        block_id_w3 = '0;
        time_value = '0;
        sent_count = 0;
        for (int i = 0; i < 16; i++)
        begin
            pool_slot[i] = (i < 12) ? 64'($urandom_range(0, 40)) : rand64();
            pool_id[i] = (i < 4) ? 256'(i) : {rand64(), rand64(), rand64(), rand64()};
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, duplicate key, undefined codes
        id = '1;
        send_beat(ACT_POP, '0, '0, 64'sh7fff_ffff_ffff_ffff);
        send_beat(ACT_INSERT, '1, id, 64'sh8000_0000_0000_0000);
        send_beat(ACT_INSERT, '0, '0, 64'sh7fff_ffff_ffff_ffff);
        send_beat(ACT_INSERT, '0, '0, -64'sd5);
        send_beat(ACT_INSERT, '0, '0, 64'sd100);
        send_beat(ACT_QUERY, '0, '0, '0);
        send_beat(ACT_QUERY, '0, 256'd1, '0);
        send_beat(ACT_REMOVE, 64'd9, '0, '0);
        send_beat(3'd5, '0, '0, '0);
        send_beat(3'd7, '1, id, '1);
        send_beat(ACT_POP, '0, '0, 64'sh8000_0000_0000_0000);
        send_beat(ACT_POP, '0, '0, -64'sd5);
        send_beat(ACT_POP, '0, '0, 64'sh7fff_ffff_ffff_ffff);
        send_beat(ACT_PUBLISH, '1, '0, '0);
        // tie on deadline and slot: lower table position first
        send_beat(ACT_INSERT, 64'd3, 256'd7, 64'sd10);
        send_beat(ACT_INSERT, 64'd3, 256'd8, 64'sd10);
        send_beat(ACT_POP, '0, '0, 64'sd10);
        send_beat(ACT_REMOVE, 64'd3, 256'd8, '0);
        // fill the table, then one dropped insert
        for (int i = 0; i <= CAPACITY; i++)
            send_beat(ACT_INSERT, 64'(i), {rand64(), 192'd0}, $signed(64'(i * 3)));
        send_beat(ACT_PUBLISH, '1, '0, '0);

        // random phases across quantum settings, extremes included
        write_quantum(32'hffff_ffff);
        random_phase(400);
        write_quantum(32'd0);
        random_phase(400);
        write_quantum(32'd7);
        random_phase(400);
        write_quantum($urandom_range(2, 1000));
        random_phase(400);
        write_quantum(32'd1);
        random_phase(400);

        drain();
        repeat (100) @(posedge clk);
        $display("%0d requests sent, %0d results checked, %0d pops returned, %0d full drops",
                 sent_count, result_count, pop_hits, full_drops);
        $display("quantum settings: max, zero, 7, random, 1");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
